// ----- rtl/core/bf5_pkg.sv -----
// Shared types and constants of the 5x5 box filter.
package bf5_pkg;

	// Frame limits and the derived counter widths
	localparam int unsigned MAX_WIDTH  = 1024;
	localparam int unsigned MAX_HEIGHT = 1024;
	localparam int unsigned DIM_W      = 11;
	localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
	localparam int unsigned ROW_W      = $clog2(MAX_HEIGHT + 3);
	localparam int unsigned OROW_W     = $clog2(MAX_HEIGHT);
	localparam int unsigned LAG_W      = $clog2(2 * MAX_WIDTH + 3);

	// Window and arithmetic
	localparam int unsigned PIX_W    = 8;
	localparam int unsigned WIN      = 5;
	localparam int unsigned LANES    = WIN - 1;
	localparam int unsigned LB_W     = LANES * PIX_W;
	localparam int unsigned CSUM_W   = 11;
	localparam int unsigned SUM_W    = 13;
	localparam int unsigned SUM_MAX  = 25 * 255;
	// floor(x / 25) == (x * 5243) >> 17 for every x up to SUM_MAX
	localparam int unsigned RECIP_25 = 5243;
	localparam int unsigned RECIP_W  = 13;
	localparam int unsigned RECIP_SH = 17;
	localparam int unsigned PROD_W   = SUM_W + RECIP_W;

	// Configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd1;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             flush;
	} pix_t;

	typedef struct packed {
		logic [PIX_W-1:0] smoothed;
		logic             last;
	} res_t;

	// Line buffer port control
	typedef struct packed {
		logic             rd_en;
		logic [COL_W-1:0] rd_addr;
		logic             wr_en;
		logic [COL_W-1:0] wr_addr;
	} lb_ctl_t;

endpackage

// ----- rtl/core/bf5_lbuf.sv -----
// Four-row line buffer: one RAM word per column, with write-to-read bypass.
module bf5_lbuf (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bf5_pkg::lb_ctl_t           ctl,
	input  logic [bf5_pkg::LB_W-1:0]   wr_data,
	output logic [bf5_pkg::LB_W-1:0]   rd_data
);

	logic [bf5_pkg::LB_W-1:0] mem [bf5_pkg::MAX_WIDTH];
	logic [bf5_pkg::LB_W-1:0] mem_q;
	logic [bf5_pkg::LB_W-1:0] byp_q;
	logic                     byp_sel_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[ctl.wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			mem_q <= mem[ctl.rd_addr];
			byp_q <= wr_data;
		end
	end

	// narrow frames read a column in the same cycle it is rewritten
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_sel_q <= 1'b0;
		end else if (ctl.rd_en) begin
			byp_sel_q <= ctl.wr_en && (ctl.wr_addr == ctl.rd_addr);
		end
	end

	assign rd_data = byp_sel_q ? byp_q : mem_q;

endmodule

// ----- rtl/core/bf5_cell.sv -----
// One window column cell: holds a column sum, hands it on, masks it at the edge.
module bf5_cell (
	input  logic                         clk,
	input  logic                         shift,
	input  logic [bf5_pkg::CSUM_W-1:0]   d,
	input  logic                         keep,
	output logic [bf5_pkg::CSUM_W-1:0]   q,
	output logic [bf5_pkg::CSUM_W-1:0]   part
);

	always_ff @(posedge clk) begin
		if (shift) begin
			q <= d;
		end
	end

	assign part = keep ? q : '0;

endmodule

// ----- rtl/core/box_filter_5x5.sv -----
// Top level of the streaming 5x5 box filter.
//
// Streaming 5x5 mean over one 8-bit plane. Samples come in raster order, one
// request per clock at full rate unless stalled; each result is the sum of
// the 25 neighbours divided by 25 (truncated), with neighbours outside the
// image counted as zero. Results lag the input by 2*width+2 requests, so
// after each frame the host sends 2*width+2 flush requests; last marks the
// final result of the frame and returns all position counters to zero.
// Throughput is one request per cycle unless stalled, set by the line buffer,
// a single RAM of MAX_WIDTH words of four samples that is read and written
// once per request. Writing either size register restarts the frame; widths
// or heights of zero act as one and larger values saturate at the maximum.
// The line buffer is not cleared: rows not yet seen in the current frame are
// masked off, so no clearing pass runs.
module box_filter_5x5 (
	input  logic                              clk,
	input  logic                              arst_n,
	// samples
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  bf5_pkg::pix_t                     pix,
	// results
	output logic                              res_valid,
	input  logic                              res_ready,
	output bf5_pkg::res_t                     res,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [bf5_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bf5_pkg::DIM_W-1:0]         cfg_data
);

	localparam int unsigned RV_W = bf5_pkg::ROW_W + 1;
	localparam int unsigned CM_W = bf5_pkg::DIM_W + 1;
	localparam int unsigned WIN  = bf5_pkg::WIN;
	localparam int unsigned PW   = bf5_pkg::PIX_W;

	function automatic logic [bf5_pkg::DIM_W-1:0] clamp_dim(
		input logic [bf5_pkg::DIM_W-1:0] v,
		input logic [bf5_pkg::DIM_W-1:0] vmax
	);
		logic [bf5_pkg::DIM_W-1:0] r;
		if (v == '0) begin
			r = bf5_pkg::DIM_W'(1);
		end else if (v > vmax) begin
			r = vmax;
		end else begin
			r = v;
		end
		return r;
	endfunction

	// ---- configuration and position state ----
	logic [bf5_pkg::DIM_W-1:0]  width_q, height_q;
	logic [bf5_pkg::COL_W-1:0]  in_col_q, out_col_q;
	logic [bf5_pkg::ROW_W-1:0]  in_row_q;
	logic [bf5_pkg::OROW_W-1:0] out_row_q;
	logic [bf5_pkg::LAG_W-1:0]  lag_cnt_q;

	logic [bf5_pkg::LAG_W-1:0]  lag;
	logic                       emit, last_now, col_end, ocol_end, orow_end;
	logic                       cfg_hit, pix_acc;

	// ---- pipeline ----
	logic                        rdy1, rdy2, rdy3, rdy4, rdy_o, fire1;
	logic                        v_s1, v_s2, v_s3, v_s4;
	logic                        emit_s1, last_s1, last_s2, last_s3, last_s4;
	logic [PW-1:0]               sample_s1;
	logic [WIN-1:0]              rowv, rowv_s1;
	logic [WIN-1:0]              cmask, cmask_s1, cmask_s2;
	logic [bf5_pkg::COL_W-1:0]   col_s1;
	logic [bf5_pkg::SUM_W-1:0]   a_s3, b_s3, sum_s4;
	logic [bf5_pkg::PROD_W-1:0]  prod;
	logic                        res_valid_q;
	bf5_pkg::res_t               res_q;

	bf5_pkg::lb_ctl_t            lb_ctl;
	logic [bf5_pkg::LB_W-1:0]    lb_rd, lb_wr;
	logic [WIN*PW-1:0]           column;
	logic [bf5_pkg::CSUM_W-1:0]  colsum;
	logic [bf5_pkg::CSUM_W-1:0]  chain [WIN+1];
	logic [bf5_pkg::CSUM_W-1:0]  part  [WIN];

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid &&
		(cfg_index == bf5_pkg::REG_WIDTH || cfg_index == bf5_pkg::REG_HEIGHT);
	assign pix_acc   = pix_valid && pix_ready;

	// Results start once 2*width+2 requests of the frame have gone in
	assign lag      = bf5_pkg::LAG_W'({width_q, 1'b0}) + bf5_pkg::LAG_W'(2);
	assign emit     = (lag_cnt_q == lag);
	assign col_end  = (bf5_pkg::DIM_W'(in_col_q) == width_q - bf5_pkg::DIM_W'(1));
	assign ocol_end = (bf5_pkg::DIM_W'(out_col_q) == width_q - bf5_pkg::DIM_W'(1));
	assign orow_end = (bf5_pkg::DIM_W'(out_row_q) == height_q - bf5_pkg::DIM_W'(1));
	assign last_now = emit && ocol_end && orow_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= bf5_pkg::DIM_W'(bf5_pkg::MAX_WIDTH);
			height_q <= bf5_pkg::DIM_W'(bf5_pkg::MAX_HEIGHT);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				bf5_pkg::REG_WIDTH: begin
					width_q <= clamp_dim(cfg_data, bf5_pkg::DIM_W'(bf5_pkg::MAX_WIDTH));
				end
				bf5_pkg::REG_HEIGHT: begin
					height_q <= clamp_dim(cfg_data, bf5_pkg::DIM_W'(bf5_pkg::MAX_HEIGHT));
				end
				default: begin
				end
			endcase
		end
	end

	// Input and output raster positions; a size write or the last result restarts them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lag_cnt_q <= '0;
		end else if (cfg_hit || (pix_acc && last_now)) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			lag_cnt_q <= '0;
		end else if (pix_acc) begin
			if (col_end) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + bf5_pkg::ROW_W'(1);
			end else begin
				in_col_q <= in_col_q + bf5_pkg::COL_W'(1);
			end
			if (!emit) begin
				lag_cnt_q <= lag_cnt_q + bf5_pkg::LAG_W'(1);
			end else if (ocol_end) begin
				out_col_q <= '0;
				out_row_q <= out_row_q + bf5_pkg::OROW_W'(1);
			end else begin
				out_col_q <= out_col_q + bf5_pkg::COL_W'(1);
			end
		end
	end

	// Row k of the entering column is k rows up; keep it only inside the frame
	always_comb begin
		for (int k = 0; k < WIN; k++) begin
			rowv[k] = (in_row_q >= bf5_pkg::ROW_W'(k)) &&
				(RV_W'(in_row_q) < RV_W'(height_q) + RV_W'(k));
		end
	end

	// Cell j holds image column out_col+2-j of the result's window
	always_comb begin
		cmask[0] = (CM_W'(out_col_q) + CM_W'(2)) < CM_W'(width_q);
		cmask[1] = (CM_W'(out_col_q) + CM_W'(1)) < CM_W'(width_q);
		cmask[2] = 1'b1;
		cmask[3] = (out_col_q != '0);
		cmask[4] = (out_col_q >= bf5_pkg::COL_W'(2));
	end

	// Backpressure: each stage moves when the next one is empty or moving
	assign rdy_o     = !res_valid_q || res_ready;
	assign rdy4      = !v_s4 || rdy_o;
	assign rdy3      = !v_s3 || rdy4;
	assign rdy2      = !v_s2 || rdy3;
	assign rdy1      = !v_s1 || rdy2;
	assign pix_ready = rdy1;
	assign fire1     = v_s1 && rdy2;

	// Stage 1: request registered, line buffer read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= pix_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_acc) begin
			sample_s1 <= pix.flush ? '0 : pix.pixel;
			emit_s1   <= emit;
			last_s1   <= last_now;
			rowv_s1   <= rowv;
			cmask_s1  <= cmask;
			col_s1    <= in_col_q;
		end
	end

	assign lb_ctl.rd_en   = pix_acc;
	assign lb_ctl.rd_addr = in_col_q;
	assign lb_ctl.wr_en   = fire1;
	assign lb_ctl.wr_addr = col_s1;
	// each lane moves one row further back
	assign lb_wr = {lb_rd[bf5_pkg::LB_W-PW-1:0], sample_s1};

	bf5_lbuf u_lbuf (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (lb_ctl),
		.wr_data (lb_wr),
		.rd_data (lb_rd)
	);

	assign column = {lb_rd, sample_s1};

	always_comb begin
		colsum = '0;
		for (int k = 0; k < WIN; k++) begin
			if (rowv_s1[k]) begin
				colsum = colsum + bf5_pkg::CSUM_W'(column[k*PW +: PW]);
			end
		end
	end

	// Stage 2: the cell chain, shifted once per request
	assign chain[0] = colsum;

	for (genvar j = 0; j < WIN; j++) begin : g_cell
		bf5_cell u_cell (
			.clk   (clk),
			.shift (fire1),
			.d     (chain[j]),
			.keep  (cmask_s2[j]),
			.q     (chain[j+1]),
			.part  (part[j])
		);
	end

	// requests before the lag is filled stop here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= fire1 && emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire1) begin
			last_s2  <= last_s1;
			cmask_s2 <= cmask_s1;
		end
	end

	// Stage 3: partial window sums
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2 && rdy3) begin
			a_s3    <= bf5_pkg::SUM_W'(part[0]) + bf5_pkg::SUM_W'(part[1]) +
				bf5_pkg::SUM_W'(part[2]);
			b_s3    <= bf5_pkg::SUM_W'(part[3]) + bf5_pkg::SUM_W'(part[4]);
			last_s3 <= last_s2;
		end
	end

	// Stage 4: full window sum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s3 && rdy4) begin
			sum_s4  <= a_s3 + b_s3;
			last_s4 <= last_s3;
		end
	end

	// Divide by 25 through the reciprocal, into the output register
	assign prod = bf5_pkg::PROD_W'(sum_s4) *
		bf5_pkg::PROD_W'(bf5_pkg::RECIP_25);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rdy_o) begin
			res_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s4 && rdy_o) begin
			res_q.smoothed <= prod[bf5_pkg::RECIP_SH +: PW];
			res_q.last     <= last_s4;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---- checks ----
	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(bf5_pkg::DIM_W'(in_col_q) < width_q) &&
		(bf5_pkg::DIM_W'(out_col_q) < width_q) &&
		(bf5_pkg::DIM_W'(out_row_q) < height_q))
		else $error("raster position outside frame");

	a_lag_bound: assert property (@(posedge clk) disable iff (!arst_n)
		lag_cnt_q <= lag)
		else $error("lag counter past lag");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && last_now && !cfg_valid) |=>
		(in_col_q == '0 && in_row_q == '0 && lag_cnt_q == '0 && out_col_q == '0))
		else $error("frame end did not restart counters");

	a_sum_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> (sum_s4 <= bf5_pkg::SUM_W'(bf5_pkg::SUM_MAX)))
		else $error("window sum out of range");

	a_stall_holds_cells: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s2 && !rdy3) |=> $stable(chain[1]))
		else $error("cell chain moved under a stalled window");

endmodule
